FILE: rtl/descriptor_slot_allocator_macros.svh
// Assertion macros shared by the descriptor slot allocator modules.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH

// Antecedent implies the consequent in the same cycle.
`define DSA_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies the consequent in the following cycle.
`define DSA_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dsa_pkg.sv
// Types and constants shared by the descriptor slot allocator modules.
package dsa_pkg;

	// Field widths.
	localparam int CAP_W      = 12;
	localparam int CAP_MAX    = (1 << CAP_W) - 1;
	localparam int HSZ_W      = 12;
	localparam int SLOT_OUT_W = 11;
	localparam int ADDR_W     = 64;
	localparam int OFF_W      = CAP_W + HSZ_W;

	// The bitmap is kept in words of 64 slots.
	localparam int ROW_W  = 64;
	localparam int ROW_SH = 6;

	// Command queue between the front and the back, a power of two deep.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Operation codes of an input item.
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	// Status codes of a result item.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_UNINIT = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_BADIDX = 3'd3;
	localparam logic [2:0] ST_FREE   = 3'd4;

	// Command kinds handed from the front to the back.
	localparam logic [2:0] CMD_REPORT = 3'd0;
	localparam logic [2:0] CMD_ALLOC  = 3'd1;
	localparam logic [2:0] CMD_FREE   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_QUERY  = 3'd4;

	typedef struct packed {
		logic [1:0]       operation;
		logic [CAP_W-1:0] index;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [SLOT_OUT_W-1:0] slot;
		logic [ADDR_W-1:0]     cpu_handle;
		logic [ADDR_W-1:0]     gpu_handle;
		logic [CAP_W-1:0]      allocated_count;
		logic [CAP_W-1:0]      remaining;
	} rsp_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [2:0]       status;
		logic [CAP_W-1:0] index;
	} cmd_t;

	typedef struct packed {
		logic [CAP_W-1:0]  capacity;
		logic [HSZ_W-1:0]  handle_size;
		logic [ADDR_W-1:0] cpu_base;
		logic [ADDR_W-1:0] gpu_base;
	} cfg_t;

endpackage

FILE: rtl/dsa_queue.sv
// Short command queue that decouples the classifying front from the executing back.
module dsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dsa_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dsa_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	dsa_pkg::cmd_t                entries_q [dsa_pkg::QUEUE_DEPTH];
	logic [dsa_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dsa_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dsa_pkg::QPTR_W:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (dsa_pkg::QPTR_W + 1)'(dsa_pkg::QUEUE_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	// Entry storage; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dsa_front.sv
// Front end: accepts request items and classifies them against the configuration.
module dsa_front (
	input  logic                      req_valid,
	output logic                      req_stall,
	input  dsa_pkg::req_t             req,
	input  logic [dsa_pkg::CAP_W-1:0] cap,
	input  logic                      q_full,
	output logic                      push,
	output dsa_pkg::cmd_t             push_cmd
);

	// An item is taken whenever the queue has room.
	assign req_stall = q_full;
	assign push      = req_valid && !q_full;

	// Errors that depend only on the configuration are settled here.
	always_comb begin
		push_cmd.index  = req.index;
		push_cmd.status = dsa_pkg::ST_OK;
		push_cmd.kind   = dsa_pkg::CMD_REPORT;
		priority if (req.operation != dsa_pkg::OP_QUERY && cap == '0) begin
			push_cmd.status = dsa_pkg::ST_UNINIT;
		end else begin
			unique case (req.operation)
				dsa_pkg::OP_ALLOC: begin
					push_cmd.kind = dsa_pkg::CMD_ALLOC;
				end
				dsa_pkg::OP_FREE: begin
					if (req.index >= cap) begin
						push_cmd.status = dsa_pkg::ST_BADIDX;
					end else begin
						push_cmd.kind = dsa_pkg::CMD_FREE;
					end
				end
				dsa_pkg::OP_CLEAR: begin
					push_cmd.kind = dsa_pkg::CMD_CLEAR;
				end
				dsa_pkg::OP_QUERY: begin
					if (req.index >= cap) begin
						push_cmd.status = dsa_pkg::ST_BADIDX;
					end else begin
						push_cmd.kind = dsa_pkg::CMD_QUERY;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/dsa_back.sv
// Back end: slot bitmap, next-fit search, handle arithmetic and the result register.
`include "descriptor_slot_allocator_macros.svh"

module dsa_back #(
	parameter int MAX_SLOTS = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dsa_pkg::cfg_t cfg,
	input  logic          clear_map,
	input  logic          q_empty,
	input  dsa_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dsa_pkg::rsp_t rsp
);

	localparam int EFF_MAX = (MAX_SLOTS < dsa_pkg::CAP_MAX) ? MAX_SLOTS : dsa_pkg::CAP_MAX;
	localparam int ROWS    = (EFF_MAX + dsa_pkg::ROW_W - 1) / dsa_pkg::ROW_W;
	localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FCHK = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]                    state_q;
	logic [dsa_pkg::CAP_W-1:0]     used_q;
	logic [dsa_pkg::CAP_W-1:0]     ptr_q;
	logic [dsa_pkg::CAP_W-1:0]     slot_q;
	logic [2:0]                    status_q;
	logic                          with_h_q;
	logic [ROW_AW-1:0]             scan_row_q;
	logic [ROW_AW-1:0]             start_row_q;
	logic [dsa_pkg::ROW_SH-1:0]    off_q;
	logic                          first_q;
	logic                          final_q;
	logic [dsa_pkg::OFF_W-1:0]     off_s1;
	logic [dsa_pkg::ADDR_W-1:0]    cpu_q;
	logic [dsa_pkg::ADDR_W-1:0]    gpu_q;
	logic                          rsp_valid_q;
	dsa_pkg::rsp_t                 rsp_q;

	// Bitmap words with one valid bit per word; an invalid word reads as all free.
	logic [dsa_pkg::ROW_W-1:0]     mem [ROWS];
	logic [ROWS-1:0]               rowvalid_q;
	logic [dsa_pkg::ROW_W-1:0]     rdata_q;
	logic                          rvalid_q;

	logic [dsa_pkg::CAP_W-1:0]     cap;
	logic [dsa_pkg::CAP_W-1:0]     cap_m1;
	logic [ROW_AW-1:0]             last_row;
	logic [dsa_pkg::CAP_W-1:0]     pos_start;
	logic [ROW_AW-1:0]             rd_addr;
	logic [ROW_AW-1:0]             wr_addr;
	logic [dsa_pkg::ROW_W-1:0]     wr_data;
	logic                          mem_we;
	logic [dsa_pkg::ROW_W-1:0]     row_data;
	logic [dsa_pkg::CAP_W-1:0]     row_base;
	logic [dsa_pkg::CAP_W-1:0]     cap_left;
	logic [dsa_pkg::ROW_W-1:0]     cap_mask;
	logic [dsa_pkg::ROW_W-1:0]     ge_off;
	logic [dsa_pkg::ROW_W-1:0]     pass_mask;
	logic [dsa_pkg::ROW_W-1:0]     cand;
	logic [dsa_pkg::ROW_W-1:0]     lowest;
	logic                          found;
	logic [dsa_pkg::ROW_SH-1:0]    bit_idx;
	logic [dsa_pkg::CAP_W-1:0]     found_slot;
	logic [dsa_pkg::CAP_W-1:0]     found_next;
	logic [ROW_AW-1:0]             next_row;
	logic                          fbit;

	assign cap       = cfg.capacity;
	assign cap_m1    = cap - 1'b1;
	assign last_row  = cap_m1[dsa_pkg::ROW_SH +: ROW_AW];
	assign pos_start = (ptr_q < cap) ? ptr_q : '0;
	assign row_data  = rvalid_q ? rdata_q : '0;
	assign q_pop     = (state_q == S_IDLE) && !q_empty && !clear_map;

	// The search begins at the pointer word, or the freed slot's word for a free.
	always_comb begin
		rd_addr = '0;
		if (state_q == S_IDLE) begin
			if (q_cmd.kind == dsa_pkg::CMD_FREE) begin
				rd_addr = q_cmd.index[dsa_pkg::ROW_SH +: ROW_AW];
			end else begin
				rd_addr = pos_start[dsa_pkg::ROW_SH +: ROW_AW];
			end
		end else if (state_q == S_SCAN) begin
			rd_addr = next_row;
		end
	end

	// Candidate free slots of the current word: below capacity, and on the
	// first and last visits of the start word only on the proper side of the pointer.
	always_comb begin
		row_base  = dsa_pkg::CAP_W'(scan_row_q) << dsa_pkg::ROW_SH;
		cap_left  = cap - row_base;
		cap_mask  = (cap_left >= dsa_pkg::CAP_W'(dsa_pkg::ROW_W)) ? '1 :
			~({dsa_pkg::ROW_W{1'b1}} << cap_left[dsa_pkg::ROW_SH-1:0]);
		ge_off    = {dsa_pkg::ROW_W{1'b1}} << off_q;
		pass_mask = final_q ? ~ge_off : (first_q ? ge_off : '1);
		cand      = ~row_data & cap_mask & pass_mask;
		lowest    = cand & (~cand + 1'b1);
		found     = |cand;
	end

	// Encode the isolated lowest free bit.
	always_comb begin
		bit_idx = '0;
		for (int b = 0; b < dsa_pkg::ROW_W; b++) begin
			bit_idx = bit_idx | (lowest[b] ? dsa_pkg::ROW_SH'(b) : '0);
		end
	end

	assign found_slot = row_base | dsa_pkg::CAP_W'(bit_idx);
	assign found_next = found_slot + 1'b1;
	assign next_row   = (scan_row_q == last_row) ? '0 : scan_row_q + 1'b1;
	assign fbit       = row_data[slot_q[dsa_pkg::ROW_SH-1:0]];

	// Word write-back for a grant or a release.
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = scan_row_q;
		wr_data = row_data | lowest;
		if (state_q == S_SCAN) begin
			mem_we = found;
		end else if (state_q == S_FCHK) begin
			mem_we  = fbit;
			wr_addr = slot_q[dsa_pkg::ROW_SH +: ROW_AW];
			wr_data = row_data & ~(dsa_pkg::ROW_W'(1) << slot_q[dsa_pkg::ROW_SH-1:0]);
		end
	end

	// Bitmap memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q  <= mem[rd_addr];
		rvalid_q <= rowvalid_q[rd_addr];
	end

	// Sequencer for one command at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			ptr_q       <= '0;
			rowvalid_q  <= '0;
			rsp_valid_q <= 1'b0;
			slot_q      <= '0;
			status_q    <= dsa_pkg::ST_OK;
			with_h_q    <= 1'b0;
			scan_row_q  <= '0;
			start_row_q <= '0;
			off_q       <= '0;
			first_q     <= 1'b0;
			final_q     <= 1'b0;
			off_s1      <= '0;
			cpu_q       <= '0;
			gpu_q       <= '0;
			rsp_q       <= '0;
		end else if (clear_map) begin
			// A capacity write empties the map.
			rowvalid_q <= '0;
			used_q     <= '0;
			ptr_q      <= '0;
			if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end else begin
			// The result register fills from a finished command and empties when taken.
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						slot_q <= q_cmd.index;
						unique case (q_cmd.kind)
							dsa_pkg::CMD_ALLOC: begin
								with_h_q <= 1'b0;
								if (used_q >= cap) begin
									status_q <= dsa_pkg::ST_FULL;
									state_q  <= S_DONE;
								end else begin
									status_q    <= dsa_pkg::ST_OK;
									scan_row_q  <= pos_start[dsa_pkg::ROW_SH +: ROW_AW];
									start_row_q <= pos_start[dsa_pkg::ROW_SH +: ROW_AW];
									off_q       <= pos_start[dsa_pkg::ROW_SH-1:0];
									first_q     <= 1'b1;
									final_q     <= 1'b0;
									state_q     <= S_SCAN;
								end
							end
							dsa_pkg::CMD_FREE: begin
								status_q <= dsa_pkg::ST_OK;
								with_h_q <= 1'b0;
								state_q  <= S_FCHK;
							end
							dsa_pkg::CMD_CLEAR: begin
								status_q   <= dsa_pkg::ST_OK;
								with_h_q   <= 1'b0;
								rowvalid_q <= '0;
								used_q     <= '0;
								ptr_q      <= '0;
								state_q    <= S_DONE;
							end
							dsa_pkg::CMD_QUERY: begin
								status_q <= dsa_pkg::ST_OK;
								with_h_q <= 1'b1;
								state_q  <= S_MUL;
							end
							default: begin
								status_q <= q_cmd.status;
								with_h_q <= 1'b0;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (found) begin
						rowvalid_q[scan_row_q] <= 1'b1;
						used_q   <= used_q + 1'b1;
						ptr_q    <= (found_next < cap) ? found_next : '0;
						slot_q   <= found_slot;
						with_h_q <= 1'b1;
						state_q  <= S_MUL;
					end else if (final_q) begin
						status_q <= dsa_pkg::ST_FULL;
						state_q  <= S_DONE;
					end else begin
						scan_row_q <= next_row;
						first_q    <= 1'b0;
						final_q    <= (next_row == start_row_q);
					end
				end
				S_FCHK: begin
					if (fbit) begin
						rowvalid_q[wr_addr] <= 1'b1;
						used_q   <= (used_q != '0) ? used_q - 1'b1 : '0;
						if (slot_q < ptr_q) begin
							ptr_q <= slot_q;
						end
						with_h_q <= 1'b1;
						state_q  <= S_MUL;
					end else begin
						status_q <= dsa_pkg::ST_FREE;
						state_q  <= S_DONE;
					end
				end
				S_MUL: begin
					off_s1  <= dsa_pkg::OFF_W'(slot_q) * dsa_pkg::OFF_W'(cfg.handle_size);
					state_q <= S_ADD;
				end
				S_ADD: begin
					cpu_q   <= cfg.cpu_base + dsa_pkg::ADDR_W'(off_s1);
					gpu_q   <= cfg.gpu_base + dsa_pkg::ADDR_W'(off_s1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status          <= status_q;
						rsp_q.slot            <= with_h_q ? slot_q[dsa_pkg::SLOT_OUT_W-1:0] : '0;
						rsp_q.cpu_handle      <= with_h_q ? cpu_q : '0;
						rsp_q.gpu_handle      <= with_h_q ? gpu_q : '0;
						rsp_q.allocated_count <= used_q;
						rsp_q.remaining       <= (cap > used_q) ? cap - used_q : '0;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A finished command is always handed to a free result register.
	`DSA_ASSERT_NXT(a_done_handoff, clk, arst_n,
		state_q == S_DONE && (!rsp_valid_q || !rsp_stall) && !clear_map,
		rsp_valid_q && state_q == S_IDLE, "result not presented after completion")
	// A written bitmap word is marked valid.
	`DSA_ASSERT_NXT(a_row_valid, clk, arst_n, mem_we && !clear_map,
		rowvalid_q[$past(wr_addr)], "written bitmap word not marked valid")
	// Taking a command always leaves the idle state.
	`DSA_ASSERT_NXT(a_pop_busy, clk, arst_n, q_pop, state_q != S_IDLE,
		"command taken but sequencer stayed idle")

endmodule

FILE: rtl/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: configuration port, front, queue and back.
//
// Next-fit bitmap allocator over up to MAX_SLOTS descriptor slots (and never more
// than 4095, the reach of the capacity register). Items enter a two-entry command
// queue and are carried out one at a time. Errors and reset-all go straight to the
// result register, a handle query only forms the handles, a free first checks the
// slot's bit, and an allocate first scans from 1 to ceil(capacity/64) + 1 of the
// 64-slot bitmap words, reading one word per cycle through the single read port of
// the bitmap memory. Handles are one 12x12 multiply and one 64-bit add, registered
// in turn. Reset and a capacity write empty the map at once via per-word valid bits.
module descriptor_slot_allocator #(
	parameter int MAX_SLOTS = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dsa_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int EFF_MAX = (MAX_SLOTS < dsa_pkg::CAP_MAX) ? MAX_SLOTS : dsa_pkg::CAP_MAX;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_HSIZE    = 2'd1;
	localparam logic [1:0] REG_CPU_BASE = 2'd2;
	localparam logic [1:0] REG_GPU_BASE = 2'd3;

	logic [dsa_pkg::CAP_W-1:0]  capacity_q;
	logic [dsa_pkg::HSZ_W-1:0]  handle_size_q;
	logic [dsa_pkg::ADDR_W-1:0] cpu_base_q;
	logic [dsa_pkg::ADDR_W-1:0] gpu_base_q;
	logic [1:0]                 reg_idx;
	logic                       wr_en;
	logic                       clear_map;
	dsa_pkg::cfg_t              cfg;
	logic                       q_full;
	logic                       q_empty;
	logic                       push;
	logic                       pop;
	dsa_pkg::cmd_t              push_cmd;
	dsa_pkg::cmd_t              head;

	// Register file, 64-bit registers at 8-byte strides.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:3];
	assign wr_en     = psel && penable && pwrite;
	assign clear_map = wr_en && (reg_idx == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q    <= '0;
			handle_size_q <= '0;
			cpu_base_q    <= '0;
			gpu_base_q    <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CAPACITY: capacity_q    <= pwdata[dsa_pkg::CAP_W-1:0];
				REG_HSIZE:    handle_size_q <= pwdata[dsa_pkg::HSZ_W-1:0];
				REG_CPU_BASE: cpu_base_q    <= pwdata;
				REG_GPU_BASE: gpu_base_q    <= pwdata;
			endcase
		end
	end

	// Read-back of the register values.
	always_comb begin
		unique case (reg_idx)
			REG_CAPACITY: prdata = 64'(capacity_q);
			REG_HSIZE:    prdata = 64'(handle_size_q);
			REG_CPU_BASE: prdata = cpu_base_q;
			REG_GPU_BASE: prdata = gpu_base_q;
		endcase
	end

	// The capacity in force saturates at the size of the map.
	always_comb begin
		cfg.capacity    = (capacity_q > dsa_pkg::CAP_W'(EFF_MAX)) ?
			dsa_pkg::CAP_W'(EFF_MAX) : capacity_q;
		cfg.handle_size = handle_size_q;
		cfg.cpu_base    = cpu_base_q;
		cfg.gpu_base    = gpu_base_q;
	end

	dsa_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cap       (cfg.capacity),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	dsa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	dsa_back #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.clear_map (clear_map),
		.q_empty   (q_empty),
		.q_cmd     (head),
		.q_pop     (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
